// File: rtl/prtt_pkg.sv
// Package for the pending request timeout tracker.
// Holds the shared types, codes and widths; no dependencies.
`timescale 1ns / 1ps

package prtt_pkg;

	localparam int DEF_TABLE_DEPTH = 16;

	localparam int OPCODE_W    = 3;
	localparam int ID_W        = 32;
	localparam int TIME_W      = 32;
	localparam int INTERVAL_W  = 16;
	localparam int THRESHOLD_W = 8;
	localparam int MISSED_W    = 8;
	localparam int PCOUNT_W    = 5;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [INTERVAL_W-1:0]  RST_INTERVAL  = 16'd10;
	localparam logic [THRESHOLD_W-1:0] RST_THRESHOLD = 8'd3;
	localparam logic [MISSED_W-1:0]    MISSED_MAX    = 8'hFF;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_CHECK  = 3'd2,
		OP_START  = 3'd3,
		OP_STOP   = 3'd4
	} prtt_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} prtt_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESPONSE_INTERVAL = 1'b0,
		CFG_MISS_THRESHOLD    = 1'b1
	} prtt_cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DRAIN,
		S_EXEC
	} prtt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic scan_clr;
		logic scan_en;
		logic exec;
	} prtt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_scan;
		logic scan_last;
		logic out_free;
	} prtt_sts_t;

endpackage

// File: rtl/prtt_if.sv
// Request and response channel interfaces of the timeout tracker.
// Depends on prtt_pkg for the field widths and the status type.
`timescale 1ns / 1ps

interface prtt_req_if import prtt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ID_W-1:0]     request_id;
	logic [TIME_W-1:0]   now_seconds;

	modport source (output valid, opcode, request_id, now_seconds, input ready);
	modport sink (input valid, opcode, request_id, now_seconds, output ready);
endinterface

interface prtt_rsp_if import prtt_pkg::*; ();
	logic                valid;
	logic                ready;
	prtt_status_t        status;
	logic                timeout_signal;
	logic [MISSED_W-1:0] missed_count;
	logic [PCOUNT_W-1:0] pending_count;

	modport source (output valid, status, timeout_signal, missed_count, pending_count,
		input ready);
	modport sink (input valid, status, timeout_signal, missed_count, pending_count,
		output ready);
endinterface

// File: rtl/prtt_ctrl.sv
// Sequencing state machine of the timeout tracker.
// Depends on prtt_pkg; drives the datapath through prtt_cmd_t.
`timescale 1ns / 1ps

module prtt_ctrl import prtt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  prtt_sts_t sts,
	output prtt_cmd_t cmd
);

	prtt_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				state_nxt = sts.needs_scan ? S_SCAN : S_EXEC;
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load     = req_valid;
				cmd.scan_clr = req_valid;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			S_DRAIN: begin
				cmd = '0;
			end
			S_EXEC: begin
				cmd.exec = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/prtt_dp.sv
// Datapath of the timeout tracker: id table, search, counters and result register.
// Depends on prtt_pkg and prtt_if; commanded by prtt_ctrl.
`timescale 1ns / 1ps

module prtt_dp import prtt_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prtt_cmd_t             cmd,
	output prtt_sts_t             sts,
	input  logic [OPCODE_W-1:0]   req_opcode,
	input  logic [ID_W-1:0]       req_request_id,
	input  logic [TIME_W-1:0]     req_now_seconds,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	prtt_rsp_if.source            rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [ID_W-1:0] mem [TABLE_DEPTH];

	logic [OPCODE_W-1:0]    opcode_q;
	logic [ID_W-1:0]        id_q;
	logic [TIME_W-1:0]      now_q;
	logic [INTERVAL_W-1:0]  interval_q;
	logic [THRESHOLD_W-1:0] threshold_q;
	logic [TIME_W-1:0]      last_q;
	logic [MISSED_W-1:0]    missed_q;
	logic                   active_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   due_q;

	logic [IDX_W-1:0]       rd_idx_q;
	logic [ID_W-1:0]        rd_data_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;
	logic                   cmp_vld_s1;
	logic                   match_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [IDX_W-1:0]       match_idx_q;

	logic                   out_valid_q;
	prtt_status_t           out_status_q;
	logic                   out_timeout_q;
	logic [MISSED_W-1:0]    out_missed_q;
	logic [PCOUNT_W-1:0]    out_pcount_q;

	prtt_status_t           status_n;
	logic                   timeout_n;
	logic [TABLE_DEPTH-1:0] valid_n;
	logic [CNT_W-1:0]       cnt_n;
	logic [TIME_W-1:0]      last_n;
	logic [MISSED_W-1:0]    missed_n;
	logic [MISSED_W-1:0]    missed_inc;
	logic                   active_n;
	logic                   mem_we;

	assign sts.needs_scan = (opcode_q == OP_ADD) || (opcode_q == OP_REMOVE);
	assign sts.scan_last  = (rd_idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign sts.out_free   = !out_valid_q || rsp.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.timeout_signal = out_timeout_q;
	assign rsp.missed_count   = out_missed_q;
	assign rsp.pending_count  = out_pcount_q;

	// The miss count saturates rather than wrapping.
	assign missed_inc = missed_q + MISSED_W'(due_q && (missed_q != MISSED_MAX));

	always_comb begin
		status_n  = ST_OK;
		timeout_n = 1'b0;
		valid_n   = valid_q;
		cnt_n     = cnt_q;
		last_n    = last_q;
		missed_n  = missed_q;
		active_n  = active_q;
		mem_we    = 1'b0;
		case (prtt_op_t'(opcode_q))
			OP_ADD: begin
				if (match_q) begin
					status_n = ST_DUP;
				end else if (!free_q) begin
					status_n = ST_FULL;
				end else begin
					mem_we              = 1'b1;
					valid_n[free_idx_q] = 1'b1;
					cnt_n               = cnt_q + CNT_W'(1);
					if (cnt_q == '0) begin
						last_n = now_q;
					end
				end
			end
			OP_REMOVE: begin
				if (!match_q) begin
					status_n = ST_NOTFOUND;
				end else begin
					valid_n[match_idx_q] = 1'b0;
					cnt_n                = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						last_n = now_q;
					end
				end
			end
			OP_CHECK: begin
				if (active_q) begin
					if (cnt_q == '0) begin
						missed_n = '0;
					end else begin
						missed_n = missed_inc;
						if (missed_inc >= threshold_q) begin
							valid_n   = '0;
							cnt_n     = '0;
							timeout_n = 1'b1;
							active_n  = 1'b0;
						end
					end
				end
			end
			OP_START: begin
				active_n = 1'b1;
				missed_n = '0;
				last_n   = now_q;
			end
			OP_STOP: begin
				valid_n  = '0;
				cnt_n    = '0;
				active_n = 1'b0;
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[free_idx_q] <= id_q;
		end
		if (cmd.scan_en) begin
			rd_data_s1 <= mem[rd_idx_q];
			cmp_idx_s1 <= rd_idx_q;
		end
		if (cmd.load) begin
			opcode_q <= req_opcode;
			id_q     <= req_request_id;
			now_q    <= req_now_seconds;
		end
		if (cmd.exec) begin
			out_status_q  <= status_n;
			out_timeout_q <= timeout_n;
			out_missed_q  <= missed_n;
			out_pcount_q  <= PCOUNT_W'(cnt_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= RST_INTERVAL;
			threshold_q <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (prtt_cfg_t'(cfg_index))
				CFG_RESPONSE_INTERVAL: interval_q  <= cfg_wdata[INTERVAL_W-1:0];
				CFG_MISS_THRESHOLD:    threshold_q <= cfg_wdata[THRESHOLD_W-1:0];
				default:               interval_q  <= interval_q;
			endcase
		end
	end

	// The elapsed-time compare is registered ahead of the update step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q <= 1'b0;
		end else if (cmd.prep) begin
			due_q <= (now_q - last_q) >= TIME_W'(interval_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
		end else begin
			cmp_vld_s1 <= cmd.scan_en;
			if (cmd.scan_clr) begin
				rd_idx_q <= '0;
				match_q  <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				if (cmd.scan_en) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				// One entry is compared per cycle, in the cycle after its read.
				if (cmp_vld_s1) begin
					if (valid_q[cmp_idx_s1]) begin
						if (!match_q && rd_data_s1 == id_q) begin
							match_q     <= 1'b1;
							match_idx_q <= cmp_idx_s1;
						end
					end else if (!free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= cmp_idx_s1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			last_q      <= '0;
			missed_q    <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				valid_q     <= valid_n;
				cnt_q       <= cnt_n;
				last_q      <= last_n;
				missed_q    <= missed_n;
				active_q    <= active_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/pending_request_timeout_tracker_unit.sv
// Top level of the pending request timeout tracker.
// Depends on prtt_pkg, prtt_if, prtt_ctrl and prtt_dp.
//
// Channel  Role    Handshake        Carries
// req      sink    valid / ready    opcode, request_id, now_seconds
// rsp      source  valid / ready    status, timeout_signal, missed_count, pending_count
// cfg      sink    cfg_we only      cfg_index, cfg_wdata
//
// Add and remove go through the prep, scan, drain and exec steps; the scan is the
// id table search that reads one entry per cycle through one memory port.
// Check, start, stop and unused opcodes go from prep straight to the exec step.
// A request is taken in the cycle after the prior result was loaded into the result register.
// The result register holds while rsp.ready is low; a finished request then waits in its
// update step. Reset clears the set, the counters and rsp.valid and loads the cfg defaults.
`timescale 1ns / 1ps

module pending_request_timeout_tracker_unit import prtt_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	prtt_req_if.sink              req,
	prtt_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	prtt_cmd_t cmd;
	prtt_sts_t sts;
	logic      ready;

	assign req.ready = ready;

	prtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prtt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_opcode      (req.opcode),
		.req_request_id  (req.request_id),
		.req_now_seconds (req.now_seconds),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.rsp             (rsp)
	);

	// Processing is one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while a previous one is still in work");

	// A timeout always empties the set and carries no error status.
	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.timeout_signal) |->
		(rsp.pending_count == '0 && rsp.status == ST_OK))
		else $error("timeout result with a non-empty set or an error status");

	// The count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (32'(rsp.pending_count) <= TABLE_DEPTH))
		else $error("pending count beyond the table depth");

	// A new result rises only while no request was being taken just before it.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared without a request in work");

endmodule
